// File: src/tksd_pkg.sv
// Shared types, key codes, byte constants and lookup functions of the key sequence decoder.
package tksd_pkg;

    // Parser phase within an escape sequence
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_SS3,
        PH_CSI,
        PH_D1,
        PH_PR1,
        PH_PR2,
        PH_D2,
        PH_D3
    } t_phase;

    // Key codes
    localparam logic [4:0] K_CHAR      = 5'd0;
    localparam logic [4:0] K_ALT       = 5'd1;
    localparam logic [4:0] K_ESC       = 5'd2;
    localparam logic [4:0] K_BKSP      = 5'd3;
    localparam logic [4:0] K_NL        = 5'd4;
    localparam logic [4:0] K_RET       = 5'd5;
    localparam logic [4:0] K_UP        = 5'd6;
    localparam logic [4:0] K_DOWN      = 5'd7;
    localparam logic [4:0] K_LEFT      = 5'd8;
    localparam logic [4:0] K_RIGHT     = 5'd9;
    localparam logic [4:0] K_HOME      = 5'd10;
    localparam logic [4:0] K_END       = 5'd11;
    localparam logic [4:0] K_INS       = 5'd12;
    localparam logic [4:0] K_DEL       = 5'd13;
    localparam logic [4:0] K_PGUP      = 5'd14;
    localparam logic [4:0] K_PGDN      = 5'd15;
    localparam logic [4:0] K_PAUSE     = 5'd16;
    localparam logic [4:0] K_BTAB      = 5'd17;
    localparam logic [4:0] K_FOCUS     = 5'd18;
    localparam logic [4:0] K_UNFOCUS   = 5'd19;
    localparam logic [4:0] K_PASTE     = 5'd20;
    localparam logic [4:0] K_PASTE_END = 5'd21;
    localparam logic [4:0] K_MENU      = 5'd22;
    localparam logic [4:0] K_FN        = 5'd23;

    // Modifiers
    localparam logic [1:0] MOD_NONE  = 2'd0;
    localparam logic [1:0] MOD_SHIFT = 2'd1;
    localparam logic [1:0] MOD_CTRL  = 2'd2;

    // Control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Function key number per two-digit code; FN_MENU marks the menu key
    localparam logic [4:0] FN_MENU = 5'd31;
    localparam int         FN_CODES = 40;
    localparam logic [4:0] FN_TABLE [FN_CODES] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd0,  5'd6,  5'd7,  5'd8,
        5'd9,  5'd10, 5'd0,  5'd11, 5'd12, 5'd13, 5'd14, 5'd0,  5'd15, 5'd31,
        5'd0,  5'd17, 5'd18, 5'd19, 5'd20, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       no_byte;
    } t_item;

    typedef struct packed {
        logic [4:0] key_code;
        logic [1:0] modifier;
        logic [4:0] fn_number;
        logic [7:0] char_value;
        logic       focused;
    } t_event;

    // Terminator of a numbered sequence: {hit, modifier}
    function automatic logic [2:0] term_mod(input logic [7:0] b);
        logic [2:0] r;
        case (b)
            "~":     r = {1'b1, MOD_NONE};
            "$":     r = {1'b1, MOD_SHIFT};
            "^":     r = {1'b1, MOD_CTRL};
            default: r = {1'b0, MOD_NONE};
        endcase
        return r;
    endfunction

    // Editing key for a one-digit code: {hit, key}
    function automatic logic [5:0] edit_key(input logic [3:0] d);
        logic [5:0] r;
        case (d)
            4'd1:    r = {1'b1, K_HOME};
            4'd2:    r = {1'b1, K_INS};
            4'd3:    r = {1'b1, K_DEL};
            4'd4:    r = {1'b1, K_END};
            4'd5:    r = {1'b1, K_PGUP};
            4'd6:    r = {1'b1, K_PGDN};
            default: r = {1'b0, K_CHAR};
        endcase
        return r;
    endfunction

    // Function key number for a two-digit code; 0 when there is none
    function automatic logic [4:0] fn_lookup(input logic [3:0] d1, input logic [3:0] d2);
        logic [6:0] code;
        logic [4:0] r;
        code = 7'(d1) * 7'd10 + 7'(d2);
        if (code < 7'(FN_CODES)) begin
            r = FN_TABLE[code[5:0]];
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// File: src/tksd_stream_if.sv
// Valid/ready channel interfaces for input bytes and key events.
interface tksd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       no_byte;

    modport source(output valid, output in_byte, output no_byte, input ready);
    modport sink(input valid, input in_byte, input no_byte, output ready);
endinterface

interface tksd_event_if;
    logic       valid;
    logic       ready;
    logic [4:0] key_code;
    logic [1:0] modifier;
    logic [4:0] fn_number;
    logic [7:0] char_value;
    logic       focused;

    modport source(output valid, output key_code, output modifier, output fn_number,
                   output char_value, output focused, input ready);
    modport sink(input valid, input key_code, input modifier, input fn_number,
                 input char_value, input focused, output ready);
endinterface

// File: src/tksd_in_reg.sv
// Input register stage: captures one byte request and holds it until the parser takes it.
module tksd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tksd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_valid,
    output tksd_pkg::t_item o_item
);
    import tksd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: src/tksd_parser.sv
// Sequence parser: phase state machine, digit and pair registers, focus flag and event decode.
module tksd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  tksd_pkg::t_item  i_item,
    output logic            o_emit,
    output tksd_pkg::t_event o_event
);
    import tksd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_first, n_first;
    logic [3:0] r_second, n_second;
    logic [3:0] r_third, n_third;
    logic [7:0] r_pair, n_pair;
    logic       r_focus, n_focus;

    logic [7:0] b;
    logic       is_digit;
    logic [2:0] tmod;
    logic [5:0] ekey;
    logic [4:0] fnum;

    assign b        = i_item.in_byte;
    assign is_digit = b inside {["0":"9"]};
    assign tmod     = term_mod(b);
    assign ekey     = edit_key(r_first);
    assign fnum     = fn_lookup(r_first, r_second);

    // Next state
    always_comb begin
        n_phase  = PH_IDLE;
        n_first  = r_first;
        n_second = r_second;
        n_third  = r_third;
        n_pair   = r_pair;
        n_focus  = r_focus;
        if (!i_item.no_byte) begin
            case (r_phase)
                PH_IDLE: begin
                    if (b == CH_ESC) n_phase = PH_ESC;
                end
                PH_ESC: begin
                    if (b == "O") n_phase = PH_SS3;
                    else if (b == "[") n_phase = PH_CSI;
                end
                PH_CSI: begin
                    if (is_digit) begin
                        n_first = b[3:0];
                        n_phase = PH_D1;
                    end else if (b == "I") begin
                        n_focus = 1'b1;
                    end else if (b == "O") begin
                        n_focus = 1'b0;
                    end
                end
                PH_D1: begin
                    if (is_digit) begin
                        n_second = b[3:0];
                        n_phase  = PH_D2;
                    end else if (b == ";") begin
                        n_phase = PH_PR1;
                    end
                end
                PH_PR1: begin
                    n_pair  = b;
                    n_phase = PH_PR2;
                end
                PH_D2: begin
                    if (is_digit) begin
                        n_third = b[3:0];
                        n_phase = PH_D3;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Event decode
    always_comb begin
        o_emit  = 1'b1;
        o_event = '{key_code: K_ESC, modifier: MOD_NONE, fn_number: 5'd0,
                    char_value: 8'd0, focused: n_focus};
        if (i_item.no_byte) begin
            o_emit = (r_phase != PH_IDLE);
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (b == CH_ESC) o_emit = 1'b0;
                    else if (b == CH_BS || b == CH_DEL) o_event.key_code = K_BKSP;
                    else if (b == CH_LF) o_event.key_code = K_NL;
                    else if (b == CH_CR) o_event.key_code = K_RET;
                    else begin
                        o_event.key_code   = K_CHAR;
                        o_event.char_value = b;
                    end
                end
                PH_ESC: begin
                    if (b == "O" || b == "[") begin
                        o_emit = 1'b0;
                    end else if (b != CH_NUL && b != CH_ESC) begin
                        o_event.key_code   = K_ALT;
                        o_event.char_value = b;
                    end
                end
                PH_SS3: begin
                    case (b)
                        "A": begin o_event.key_code = K_UP;    o_event.modifier = MOD_CTRL; end
                        "B": begin o_event.key_code = K_DOWN;  o_event.modifier = MOD_CTRL; end
                        "c": begin o_event.key_code = K_LEFT;  o_event.modifier = MOD_CTRL; end
                        "d": begin o_event.key_code = K_RIGHT; o_event.modifier = MOD_CTRL; end
                        "P": begin o_event.key_code = K_FN; o_event.fn_number = 5'd1; end
                        "Q": begin o_event.key_code = K_FN; o_event.fn_number = 5'd2; end
                        "R": begin o_event.key_code = K_FN; o_event.fn_number = 5'd3; end
                        "S": begin o_event.key_code = K_FN; o_event.fn_number = 5'd4; end
                        default: o_event.key_code = K_ESC;
                    endcase
                end
                PH_CSI: begin
                    if (is_digit) begin
                        o_emit = 1'b0;
                    end else begin
                        case (b)
                            "a": begin o_event.key_code = K_UP;    o_event.modifier = MOD_SHIFT; end
                            "b": begin o_event.key_code = K_DOWN;  o_event.modifier = MOD_SHIFT; end
                            "c": begin o_event.key_code = K_RIGHT; o_event.modifier = MOD_SHIFT; end
                            "d": begin o_event.key_code = K_LEFT;  o_event.modifier = MOD_SHIFT; end
                            "A": o_event.key_code = K_UP;
                            "B": o_event.key_code = K_DOWN;
                            "C": o_event.key_code = K_RIGHT;
                            "D": o_event.key_code = K_LEFT;
                            "H": o_event.key_code = K_HOME;
                            "P": o_event.key_code = K_PAUSE;
                            "F": o_event.key_code = K_END;
                            "Z": o_event.key_code = K_BTAB;
                            "I": o_event.key_code = K_FOCUS;
                            "O": o_event.key_code = K_UNFOCUS;
                            default: o_event.key_code = K_ESC;
                        endcase
                    end
                end
                PH_D1: begin
                    if (is_digit || b == ";") begin
                        o_emit = 1'b0;
                    end else if (tmod[2] && ekey[5]) begin
                        o_event.key_code = ekey[4:0];
                        o_event.modifier = tmod[1:0];
                    end
                end
                PH_PR1: o_emit = 1'b0;
                PH_PR2: begin
                    if (r_pair == "2" || r_pair == "5") begin
                        o_event.modifier = (r_pair == "2") ? MOD_SHIFT : MOD_CTRL;
                        case (b)
                            "A": o_event.key_code = K_UP;
                            "B": o_event.key_code = K_DOWN;
                            "C": o_event.key_code = K_RIGHT;
                            "D": o_event.key_code = K_LEFT;
                            default: begin
                                o_event.key_code = K_ESC;
                                o_event.modifier = MOD_NONE;
                            end
                        endcase
                    end
                end
                PH_D2: begin
                    if (is_digit) begin
                        o_emit = 1'b0;
                    end else if (tmod[2] && fnum == FN_MENU) begin
                        o_event.key_code = K_MENU;
                        o_event.modifier = tmod[1:0];
                    end else if (tmod[2] && fnum != 5'd0) begin
                        o_event.key_code  = K_FN;
                        o_event.modifier  = tmod[1:0];
                        o_event.fn_number = fnum;
                    end
                end
                PH_D3: begin
                    if (b == "~" && r_first == 4'd2 && r_second == 4'd0) begin
                        if (r_third == 4'd0) o_event.key_code = K_PASTE;
                        else if (r_third == 4'd1) o_event.key_code = K_PASTE_END;
                    end
                end
                default: o_event.key_code = K_ESC;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_first  <= 4'd0;
            r_second <= 4'd0;
            r_third  <= 4'd0;
            r_pair   <= 8'd0;
            r_focus  <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
            r_pair   <= n_pair;
            r_focus  <= n_focus;
        end
    end

endmodule

// File: src/tksd_out_reg.sv
// Result register: holds one key event until the downstream side takes it.
module tksd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tksd_pkg::t_event  i_event,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output tksd_pkg::t_event  o_event
);
    import tksd_pkg::*;

    logic   r_valid;
    t_event r_event;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_event <= i_event;
        end
    end

endmodule

// File: src/terminal_key_sequence_decoder.sv
// The parser decodes the held request; its key event is registered in the result register.
// Throughput: one byte per cycle; the parser steps one byte per cycle through its phase register.
// A byte that ends no sequence produces no event; a stalled event register holds the parser.
// Reset (synchronous, active low) returns the parser to idle, clears the digit and pair
// registers and the focus flag, and empties the input and result registers.
// Top level: input register, sequence parser and result register in one single-pass pipeline.
module terminal_key_sequence_decoder (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tksd_byte_if.sink    i_req,
    tksd_event_if.source o_evt
);
    import tksd_pkg::*;

    t_item  req_item;
    t_item  stage_item;
    t_event dec_event;
    t_event out_event;
    logic   stage_valid;
    logic   out_space;
    logic   fire;
    logic   emit;

    // Pack the incoming request fields
    assign req_item = '{in_byte: i_req.in_byte, no_byte: i_req.no_byte};

    // Advance the parser whenever a byte waits and the result register can take a result
    assign fire = stage_valid && out_space;

    tksd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_item  (req_item),
        .i_take  (fire),
        .o_ready (i_req.ready),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // Decode the held byte against the current phase; update state only on fire
    tksd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (stage_item),
        .o_emit  (emit),
        .o_event (dec_event)
    );

    // Hold the event until the consumer takes it
    tksd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && emit),
        .i_event (dec_event),
        .i_ready (o_evt.ready),
        .o_space (out_space),
        .o_valid (o_evt.valid),
        .o_event (out_event)
    );

    // Drive the event channel payload
    assign o_evt.key_code   = out_event.key_code;
    assign o_evt.modifier   = out_event.modifier;
    assign o_evt.fn_number  = out_event.fn_number;
    assign o_evt.char_value = out_event.char_value;
    assign o_evt.focused    = out_event.focused;

endmodule

// File: src/tksd_checker.sv
// Port-level checker for the key sequence decoder and its bind to the top level.
module tksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_key_code,
    input logic [1:0] i_modifier,
    input logic [4:0] i_fn_number,
    input logic [7:0] i_char_value,
    input logic       i_focused
);
    import tksd_pkg::*;

    // Hold the key, modifier, function number and character of a stalled event unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_key_code)
            && $stable(i_modifier) && $stable(i_fn_number) && $stable(i_char_value))
        else $error("stalled key event changed");

    a_fn_only_function: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fn_number != 5'd0 |-> i_key_code == K_FN)
        else $error("function number on a non-function key");

    a_char_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_value != 8'd0 |-> i_key_code == K_CHAR || i_key_code == K_ALT)
        else $error("character value on a named key");

    a_focus_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_code == K_FOCUS || i_key_code == K_UNFOCUS)
            |-> i_focused == (i_key_code == K_FOCUS))
        else $error("focus flag does not follow focus event");

    a_char_no_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_code == K_CHAR || i_key_code == K_ALT) |-> i_modifier == MOD_NONE)
        else $error("modifier on a character event");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_evt.valid),
    .i_out_ready  (o_evt.ready),
    .i_key_code   (o_evt.key_code),
    .i_modifier   (o_evt.modifier),
    .i_fn_number  (o_evt.fn_number),
    .i_char_value (o_evt.char_value),
    .i_focused    (o_evt.focused)
);

// File: sim/tb_top.sv
// Self-checking testbench of the terminal key sequence decoder: directed table, then random sequences.
`timescale 1ns / 100ps

module tb_top;
    import tksd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // generous bound on the whole run
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 250;     // random requests per idling phase
    localparam int PHASES       = 4;

    // Idling per phase: none, sender idle, receiver stalling, both
    localparam int GAP_PCT   [PHASES] = '{0, 71, 0, 29};
    localparam int STALL_PCT [PHASES] = '{0, 0, 71, 29};

    // Final bytes and pieces that well-formed sequences are built from
    localparam logic [7:0] SS3_FINALS   [8]  = '{"A", "B", "c", "d", "P", "Q", "R", "S"};
    localparam logic [7:0] CSI_FINALS   [14] = '{"a", "b", "c", "d", "A", "B", "C", "D",
                                                 "H", "P", "F", "Z", "I", "O"};
    localparam logic [7:0] TERM_BYTES   [3]  = '{"~", "$", "^"};
    localparam logic [7:0] ARROW_FINALS [4]  = '{"A", "B", "C", "D"};
    localparam logic [7:0] CTRL_BYTES   [4]  = '{CH_BS, CH_DEL, CH_LF, CH_CR};
    localparam int         FN_CODE_LIST [20] = '{11, 12, 13, 14, 15, 17, 18, 19, 20, 21,
                                                 23, 24, 25, 26, 28, 29, 31, 32, 33, 34};

    // Directed row: request, whether the event is typed in, and the typed event
    typedef struct packed {
        t_item  req;
        logic   typed;
        t_event want;
    } t_dir_row;

    localparam t_event NO_EVT = '0;
    localparam int     DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        {CH_NUL, 1'b1, 1'b0, NO_EVT},                                          // empty read, idle
        {CH_NUL, 1'b0, 1'b1, {K_CHAR, MOD_NONE, 5'd0, 8'h00, 1'b0}},           // lowest byte
        {8'hFF,  1'b0, 1'b1, {K_CHAR, MOD_NONE, 5'd0, 8'hFF, 1'b0}},           // highest byte
        {CH_BS,  1'b0, 1'b1, {K_BKSP, MOD_NONE, 5'd0, 8'h00, 1'b0}},           // backspace
        {CH_DEL, 1'b0, 1'b1, {K_BKSP, MOD_NONE, 5'd0, 8'h00, 1'b0}},
        {CH_LF,  1'b0, 1'b1, {K_NL,   MOD_NONE, 5'd0, 8'h00, 1'b0}},
        {CH_CR,  1'b0, 1'b1, {K_RET,  MOD_NONE, 5'd0, 8'h00, 1'b0}},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // ESC NUL
        {CH_NUL, 1'b0, 1'b1, {K_ESC,  MOD_NONE, 5'd0, 8'h00, 1'b0}},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // ESC ESC
        {CH_ESC, 1'b0, 1'b1, {K_ESC,  MOD_NONE, 5'd0, 8'h00, 1'b0}},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // SS3 F1
        {8'h4F,  1'b0, 1'b0, NO_EVT},
        {8'h50,  1'b0, 1'b0, NO_EVT},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // CSI focus
        {8'h5B,  1'b0, 1'b0, NO_EVT},
        {8'h49,  1'b0, 1'b0, NO_EVT},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // paste marker
        {8'h5B,  1'b0, 1'b0, NO_EVT},
        {8'h32,  1'b0, 1'b0, NO_EVT},
        {8'h30,  1'b0, 1'b0, NO_EVT},
        {8'h30,  1'b0, 1'b0, NO_EVT},
        {8'h7E,  1'b0, 1'b0, NO_EVT},
        {CH_ESC, 1'b0, 1'b0, NO_EVT},                                          // empty read mid-sequence
        {8'hA5,  1'b1, 1'b1, {K_ESC,  MOD_NONE, 5'd0, 8'h00, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    tksd_byte_if  req_ch ();
    tksd_event_if evt_ch ();

    terminal_key_sequence_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_evt   (evt_ch)
    );

    // Predicted parser state, kept apart from the block
    t_phase     seq_phase;
    logic [3:0] code_d1;
    logic [3:0] code_d2;
    logic [3:0] code_d3;
    logic [7:0] pair_lead;
    logic       win_focus;

    t_event key_events_due [$];  // key events still owed by the block, oldest first

    int          gap_pct;
    int          stall_pct;
    int          mismatches;
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Bound the run; a hang anywhere ends here
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Map a numbered-sequence terminator to its modifier; -1 when it is none
    function automatic int term_mod_of(input logic [7:0] b);
        int r;
        case (b)
            "~":     r = int'(MOD_NONE);
            "$":     r = int'(MOD_SHIFT);
            "^":     r = int'(MOD_CTRL);
            default: r = -1;
        endcase
        return r;
    endfunction

    // Return the given byte most of the time, a random byte otherwise
    function automatic logic [7:0] mostly(input logic [7:0] b, input int pct);
        logic [7:0] r;
        r = ($urandom_range(99) < pct) ? b : 8'($urandom_range(255));
        return r;
    endfunction

    // Advance the predicted parser by one byte request; report the key event it completes
    task automatic decode_key(input t_item it, output bit fired, output t_event ev);
        logic [7:0] b;
        logic [4:0] k;
        logic [1:0] m;
        logic [4:0] f;
        logic [7:0] c;
        logic [4:0] ek;
        bit         ek_hit;
        int         tm;
        int         code;
        logic [4:0] fnum;
        bit         menu;
        b     = it.in_byte;
        fired = 1'b1;
        k     = K_ESC;
        m     = MOD_NONE;
        f     = 5'd0;
        c     = 8'h00;
        if (it.no_byte) begin
            // An empty read only matters inside a sequence
            fired = (seq_phase != PH_IDLE);
        end else begin
            case (seq_phase)
                PH_IDLE: begin
                    if (b == CH_ESC) begin
                        fired     = 1'b0;
                        seq_phase = PH_ESC;
                    end else if (b == CH_BS || b == CH_DEL) begin
                        k = K_BKSP;
                    end else if (b == CH_LF) begin
                        k = K_NL;
                    end else if (b == CH_CR) begin
                        k = K_RET;
                    end else begin
                        k = K_CHAR;
                        c = b;
                    end
                end
                PH_ESC: begin
                    if (b == CH_NUL || b == CH_ESC) begin
                        k = K_ESC;
                    end else if (b == "O") begin
                        fired     = 1'b0;
                        seq_phase = PH_SS3;
                    end else if (b == "[") begin
                        fired     = 1'b0;
                        seq_phase = PH_CSI;
                    end else begin
                        k = K_ALT;
                        c = b;
                    end
                end
                PH_SS3: begin
                    case (b)
                        "A":     begin k = K_UP;    m = MOD_CTRL; end
                        "B":     begin k = K_DOWN;  m = MOD_CTRL; end
                        "c":     begin k = K_LEFT;  m = MOD_CTRL; end
                        "d":     begin k = K_RIGHT; m = MOD_CTRL; end
                        "P":     begin k = K_FN;    f = 5'd1; end
                        "Q":     begin k = K_FN;    f = 5'd2; end
                        "R":     begin k = K_FN;    f = 5'd3; end
                        "S":     begin k = K_FN;    f = 5'd4; end
                        default: k = K_ESC;
                    endcase
                end
                PH_CSI: begin
                    if (b >= "0" && b <= "9") begin
                        code_d1   = b[3:0];
                        fired     = 1'b0;
                        seq_phase = PH_D1;
                    end else begin
                        case (b)
                            "a":     begin k = K_UP;    m = MOD_SHIFT; end
                            "b":     begin k = K_DOWN;  m = MOD_SHIFT; end
                            "c":     begin k = K_RIGHT; m = MOD_SHIFT; end
                            "d":     begin k = K_LEFT;  m = MOD_SHIFT; end
                            "A":     k = K_UP;
                            "B":     k = K_DOWN;
                            "C":     k = K_RIGHT;
                            "D":     k = K_LEFT;
                            "H":     k = K_HOME;
                            "P":     k = K_PAUSE;
                            "F":     k = K_END;
                            "Z":     k = K_BTAB;
                            "I":     begin k = K_FOCUS;   win_focus = 1'b1; end
                            "O":     begin k = K_UNFOCUS; win_focus = 1'b0; end
                            default: k = K_ESC;
                        endcase
                    end
                end
                PH_D1: begin
                    if (b >= "0" && b <= "9") begin
                        code_d2   = b[3:0];
                        fired     = 1'b0;
                        seq_phase = PH_D2;
                    end else if (b == ";") begin
                        fired     = 1'b0;
                        seq_phase = PH_PR1;
                    end else begin
                        ek_hit = 1'b1;
                        case (code_d1)
                            4'd1:    ek = K_HOME;
                            4'd2:    ek = K_INS;
                            4'd3:    ek = K_DEL;
                            4'd4:    ek = K_END;
                            4'd5:    ek = K_PGUP;
                            4'd6:    ek = K_PGDN;
                            default: begin ek = K_ESC; ek_hit = 1'b0; end
                        endcase
                        tm = term_mod_of(b);
                        if (tm >= 0 && ek_hit) begin
                            k = ek;
                            m = 2'(tm);
                        end
                    end
                end
                PH_PR1: begin
                    // The digit before ';' is dropped; hold the byte after it
                    pair_lead = b;
                    fired     = 1'b0;
                    seq_phase = PH_PR2;
                end
                PH_PR2: begin
                    if (pair_lead == "2" || pair_lead == "5") begin
                        m = (pair_lead == "2") ? MOD_SHIFT : MOD_CTRL;
                        case (b)
                            "A":     k = K_UP;
                            "B":     k = K_DOWN;
                            "C":     k = K_RIGHT;
                            "D":     k = K_LEFT;
                            default: begin k = K_ESC; m = MOD_NONE; end
                        endcase
                    end
                end
                PH_D2: begin
                    if (b >= "0" && b <= "9") begin
                        code_d3   = b[3:0];
                        fired     = 1'b0;
                        seq_phase = PH_D3;
                    end else begin
                        code = int'(code_d1) * 10 + int'(code_d2);
                        fnum = 5'd0;
                        menu = 1'b0;
                        case (code)
                            11, 12, 13, 14, 15: fnum = 5'(code - 10);
                            17, 18, 19, 20, 21: fnum = 5'(code - 11);
                            23, 24, 25, 26:     fnum = 5'(code - 12);
                            28:                 fnum = 5'd15;
                            29:                 menu = 1'b1;
                            31, 32, 33, 34:     fnum = 5'(code - 14);
                            default:            fnum = 5'd0;
                        endcase
                        tm = term_mod_of(b);
                        if (tm >= 0 && menu) begin
                            k = K_MENU;
                            m = 2'(tm);
                        end else if (tm >= 0 && fnum != 5'd0) begin
                            k = K_FN;
                            m = 2'(tm);
                            f = fnum;
                        end
                    end
                end
                PH_D3: begin
                    // Only 200~ and 201~ mean something with three digits
                    if (b == "~" && code_d1 == 4'd2 && code_d2 == 4'd0) begin
                        if (code_d3 == 4'd0) begin
                            k = K_PASTE;
                        end else if (code_d3 == 4'd1) begin
                            k = K_PASTE_END;
                        end
                    end
                end
                default: k = K_ESC;
            endcase
        end
        if (fired) begin
            ev        = {k, m, f, c, win_focus};
            seq_phase = PH_IDLE;
        end else begin
            ev = NO_EVT;
        end
    endtask

    // Offer one byte request after a random idle spell; predict on acceptance
    task automatic send_byte(input t_item it, output bit fired, output t_event ev);
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.in_byte <= it.in_byte;
        req_ch.no_byte <= it.no_byte;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        decode_key(it, fired, ev);
    endtask

    // Drop valid and hold off until every owed event has come out
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (key_events_due.size() != 0) @(posedge i_clk);
    endtask

    // Build one random sequence, mostly well formed, and send it; return its length
    task automatic send_random_sequence(output int sent);
        t_item  seq [$];
        int     kind;
        int     code;
        int     depth;
        bit     fired;
        t_event ev;
        kind = $urandom_range(99);
        if (kind < 15) begin
            seq.push_back({8'($urandom_range(255)), 1'b0});
        end else if (kind < 22) begin
            seq.push_back({CTRL_BYTES[$urandom_range(3)], 1'b0});
        end else if (kind < 30) begin
            // Alt character, or escape on NUL / ESC
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'($urandom_range(255)), 1'b0});
        end else if (kind < 40) begin
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h4F, 1'b0});
            seq.push_back({mostly(SS3_FINALS[$urandom_range(7)], 85), 1'b0});
        end else if (kind < 52) begin
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h5B, 1'b0});
            seq.push_back({mostly(CSI_FINALS[$urandom_range(13)], 85), 1'b0});
        end else if (kind < 63) begin
            // One-digit editing key
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h5B, 1'b0});
            seq.push_back({{4'h3, 4'($urandom_range(9))}, 1'b0});
            seq.push_back({mostly(TERM_BYTES[$urandom_range(2)], 85), 1'b0});
        end else if (kind < 73) begin
            // Digit ';' pair form
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h5B, 1'b0});
            seq.push_back({{4'h3, 4'($urandom_range(9))}, 1'b0});
            seq.push_back({8'h3B, 1'b0});
            seq.push_back({mostly($urandom_range(1) ? 8'h35 : 8'h32, 80), 1'b0});
            seq.push_back({mostly(ARROW_FINALS[$urandom_range(3)], 80), 1'b0});
        end else if (kind < 85) begin
            // Two-digit function or menu key
            code = ($urandom_range(99) < 80) ? FN_CODE_LIST[$urandom_range(19)]
                                             : int'($urandom_range(99));
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h5B, 1'b0});
            seq.push_back({{4'h3, 4'(code / 10)}, 1'b0});
            seq.push_back({{4'h3, 4'(code % 10)}, 1'b0});
            seq.push_back({mostly(TERM_BYTES[$urandom_range(2)], 85), 1'b0});
        end else if (kind < 91) begin
            // Paste markers, or any three digits
            seq.push_back({CH_ESC, 1'b0});
            seq.push_back({8'h5B, 1'b0});
            if ($urandom_range(99) < 60) begin
                seq.push_back({8'h32, 1'b0});
                seq.push_back({8'h30, 1'b0});
                seq.push_back({{4'h3, 4'($urandom_range(1))}, 1'b0});
            end else begin
                repeat (3) seq.push_back({{4'h3, 4'($urandom_range(9))}, 1'b0});
            end
            seq.push_back({mostly(8'h7E, 85), 1'b0});
        end else if (kind < 96) begin
            // Cut a sequence short by an empty read at some depth
            depth = $urandom_range(5);
            seq.push_back({CH_ESC, 1'b0});
            if (depth == 1) begin
                seq.push_back({8'h4F, 1'b0});
            end else if (depth >= 2) begin
                seq.push_back({8'h5B, 1'b0});
                if (depth >= 3) begin
                    seq.push_back({8'h32, 1'b0});
                end
                if (depth == 4) begin
                    seq.push_back({8'h3B, 1'b0});
                    seq.push_back({8'h35, 1'b0});
                end else if (depth == 5) begin
                    seq.push_back({8'h30, 1'b0});
                    seq.push_back({8'h30, 1'b0});
                end
            end
            seq.push_back({8'($urandom_range(255)), 1'b1});
        end else begin
            seq.push_back({8'($urandom_range(255)), 1'b1});
        end
        foreach (seq[i]) begin
            send_byte(seq[i], fired, ev);
            if (fired) key_events_due.push_back(ev);
        end
        sent = seq.size();
    endtask

    // Receiver: check each accepted event against the oldest owed one, stall at random
    initial begin
        t_event got;
        t_event want;
        bit     bad;
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
                got = {evt_ch.key_code, evt_ch.modifier, evt_ch.fn_number,
                       evt_ch.char_value, evt_ch.focused};
                if (key_events_due.size() == 0) begin
                    $display("%0t: unexpected key event: key=%0d mod=%0d fn=%0d ch=%02h foc=%0d",
                             $time, got.key_code, got.modifier, got.fn_number,
                             got.char_value, got.focused);
                    mismatches++;
                end else begin
                    want = key_events_due.pop_front();
                    bad  = (got.key_code !== want.key_code) || (got.modifier !== want.modifier)
                        || (got.fn_number !== want.fn_number)
                        || (got.char_value !== want.char_value)
                        || (got.focused !== want.focused);
                    if (bad) begin
                        $display("%0t: key event mismatch: expected key=%0d mod=%0d fn=%0d ch=%02h foc=%0d",
                                 $time, want.key_code, want.modifier, want.fn_number,
                                 want.char_value, want.focused);
                        $display("%0t:                       actual key=%0d mod=%0d fn=%0d ch=%02h foc=%0d",
                                 $time, got.key_code, got.modifier, got.fn_number,
                                 got.char_value, got.focused);
                        mismatches++;
                    end
                end
            end
            evt_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Sender: reset, directed table, then random sequences over the idling phases
    initial begin
        bit     fired;
        t_event ev;
        int     sent;
        int     n;
        mismatches     = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        seq_phase      = PH_IDLE;
        code_d1        = 4'd0;
        code_d2        = 4'd0;
        code_d3        = 4'd0;
        pair_lead      = 8'h00;
        win_focus      = 1'b0;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.in_byte <= 8'h00;
        req_ch.no_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; typed rows carry their own event, the rest use the predictor
        foreach (DIR_TABLE[i]) begin
            send_byte(DIR_TABLE[i].req, fired, ev);
            if (DIR_TABLE[i].typed) begin
                key_events_due.push_back(DIR_TABLE[i].want);
            end else if (fired) begin
                key_events_due.push_back(ev);
            end
        end
        wait_for_drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            sent      = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_sequence(n);
                sent += n;
            end
            // Hold the sender until the block has paid out every event
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && key_events_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/tksd_pkg.sv
src/tksd_stream_if.sv
src/tksd_in_reg.sv
src/tksd_parser.sv
src/tksd_out_reg.sv
src/terminal_key_sequence_decoder.sv
src/tksd_checker.sv
sim/tb_top.sv
